// ----- sv/fpalu_pkg.sv -----
// Shared opcodes, widths and pipeline sideband type for the Q24.8 fixed-point ALU.
package fpalu_pkg;

  localparam int WORD_W = 32;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } opcode_t;

  typedef struct packed {
    logic [WORD_W-1:0] res;
    logic              cmp;
    logic              dz;
    logic              is_div;
    logic              qneg;
  } side_t;

endpackage

// ----- sv/fpalu_div_pipe.sv -----
// Unsigned restoring divider, one quotient bit per pipeline stage, with sideband.
module fpalu_div_pipe #(
  parameter int FRAC_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_vld,
  input  logic [fpalu_pkg::WORD_W+FRAC_BITS-1:0] in_dividend,
  input  logic [fpalu_pkg::WORD_W-1:0]    in_divisor,
  input  fpalu_pkg::side_t                in_side,
  output logic                            out_vld,
  output logic [fpalu_pkg::WORD_W+FRAC_BITS-1:0] out_quotient,
  output fpalu_pkg::side_t                out_side
);
  import fpalu_pkg::*;

  localparam int DW = WORD_W + FRAC_BITS;

  logic              vld_r  [DW];
  logic [WORD_W-1:0] rem_r  [DW];
  logic [DW-1:0]     dnd_r  [DW];
  logic [WORD_W-1:0] dsr_r  [DW];
  side_t             side_r [DW];

  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic              vld_in;
    logic [WORD_W-1:0] rem_in;
    logic [DW-1:0]     dnd_in;
    logic [WORD_W-1:0] dsr_in;
    side_t             side_in;
    logic [WORD_W:0]   trial;
    logic              take;
    logic [WORD_W-1:0] rem_nxt;
    logic [DW-1:0]     dnd_nxt;

    if (k == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rem_in  = '0;
      assign dnd_in  = in_dividend;
      assign dsr_in  = in_divisor;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign dnd_in  = dnd_r[k-1];
      assign dsr_in  = dsr_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign trial   = {rem_in, dnd_in[DW-1]} - {1'b0, dsr_in};
    assign take    = ~trial[WORD_W];
    assign rem_nxt = take ? trial[WORD_W-1:0] : {rem_in[WORD_W-2:0], dnd_in[DW-1]};
    assign dnd_nxt = {dnd_in[DW-2:0], take};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        dnd_r[k]  <= dnd_nxt;
        dsr_r[k]  <= dsr_in;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_vld      = vld_r[DW-1];
  assign out_quotient = dnd_r[DW-1];
  assign out_side     = side_r[DW-1];

endmodule

// ----- sv/fixed_point_q24_8_alu.sv -----
// Top level of the pipelined signed fixed-point ALU.
// Every item passes through the same stages from acceptance to its result, whatever
// the opcode: an input stage, an operand stage holding the 32x32 product and the
// divider setup, one divider stage per quotient bit (32 + FRAC_BITS of them), and
// the output register. A new item is taken in every cycle that in_stall is low;
// in_stall rises only while a finished result waits under out_stall, and the whole
// pipe then holds. No state is kept between items.
module fixed_point_q24_8_alu #(
  parameter int FRAC_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [3:0]                   in_opcode,
  input  logic signed [fpalu_pkg::WORD_W-1:0] in_operand_a,
  input  logic signed [fpalu_pkg::WORD_W-1:0] in_operand_b,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [fpalu_pkg::WORD_W-1:0] out_result_value,
  output logic                         out_compare_true,
  output logic                         out_divide_by_zero
);
  import fpalu_pkg::*;

  localparam int DW = WORD_W + FRAC_BITS;

  logic en;

  logic                     v1_r;
  opcode_t                  op1_r;
  logic signed [WORD_W-1:0] a1_r;
  logic signed [WORD_W-1:0] b1_r;

  logic                       v2_r;
  opcode_t                    op2_r;
  logic signed [2*WORD_W-1:0] prod2_r;
  logic [WORD_W-1:0]          res2_r;
  logic                       cmp2_r;
  logic                       dz2_r;
  logic                       is_div2_r;
  logic                       qneg2_r;
  logic [DW-1:0]              dnd2_r;
  logic [WORD_W-1:0]          dsr2_r;

  logic                       lt;
  logic                       gt;
  logic                       eq;
  logic                       cmp_nxt;
  logic                       is_cmp;
  logic [WORD_W-1:0]          res_nxt;
  logic [WORD_W-1:0]          abs_a;
  logic [WORD_W-1:0]          abs_b;
  logic signed [2*WORD_W-1:0] prod_nxt;

  logic signed [2*WORD_W-1:0] prod_sh;
  side_t                      side2;

  logic              dv_vld;
  logic [DW-1:0]     dv_quo;
  side_t             dv_side;
  logic [WORD_W-1:0] quo_w;
  logic [WORD_W-1:0] out_res_nxt;

  logic                     out_valid_r;
  logic [WORD_W-1:0]        out_res_r;
  logic                     out_cmp_r;
  logic                     out_dz_r;

  assign en       = ~(out_valid_r & out_stall);
  assign in_stall = ~en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r <= opcode_t'(in_opcode);
      a1_r  <= in_operand_a;
      b1_r  <= in_operand_b;
    end
  end

  always_comb begin
    lt       = a1_r < b1_r;
    gt       = a1_r > b1_r;
    eq       = a1_r == b1_r;
    cmp_nxt  = 1'b0;
    is_cmp   = 1'b0;
    res_nxt  = '0;
    prod_nxt = (2*WORD_W)'(a1_r) * (2*WORD_W)'(b1_r);
    abs_a    = a1_r[WORD_W-1] ? WORD_W'(-a1_r) : a1_r;
    abs_b    = b1_r[WORD_W-1] ? WORD_W'(-b1_r) : b1_r;
    case (op1_r)
      OP_ADD:      res_nxt = a1_r + b1_r;
      OP_SUB:      res_nxt = a1_r - b1_r;
      OP_GT:       begin is_cmp = 1'b1; cmp_nxt = gt;       end
      OP_LT:       begin is_cmp = 1'b1; cmp_nxt = lt;       end
      OP_GE:       begin is_cmp = 1'b1; cmp_nxt = ~lt;      end
      OP_LE:       begin is_cmp = 1'b1; cmp_nxt = ~gt;      end
      OP_EQ:       begin is_cmp = 1'b1; cmp_nxt = eq;       end
      OP_NE:       begin is_cmp = 1'b1; cmp_nxt = ~eq;      end
      OP_MIN:      res_nxt = lt ? a1_r : b1_r;
      OP_MAX:      res_nxt = gt ? a1_r : b1_r;
      OP_INC:      res_nxt = a1_r + WORD_W'(1);
      OP_DEC:      res_nxt = a1_r - WORD_W'(1);
      OP_FROM_INT: res_nxt = a1_r << FRAC_BITS;
      OP_TO_INT:   res_nxt = a1_r >>> FRAC_BITS;
      default:     res_nxt = '0;
    endcase
    if (is_cmp) begin
      res_nxt = {{(WORD_W-1){1'b0}}, cmp_nxt};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2_r     <= op1_r;
      prod2_r   <= prod_nxt;
      res2_r    <= res_nxt;
      cmp2_r    <= cmp_nxt;
      is_div2_r <= op1_r == OP_DIV;
      dz2_r     <= (op1_r == OP_DIV) && (b1_r == '0);
      qneg2_r   <= a1_r[WORD_W-1] ^ b1_r[WORD_W-1];
      dnd2_r    <= {abs_a, {FRAC_BITS{1'b0}}};
      dsr2_r    <= abs_b;
    end
  end

  always_comb begin
    prod_sh      = prod2_r >>> FRAC_BITS;
    side2.res    = (op2_r == OP_MUL) ? prod_sh[WORD_W-1:0] : res2_r;
    side2.cmp    = cmp2_r;
    side2.dz     = dz2_r;
    side2.is_div = is_div2_r;
    side2.qneg   = qneg2_r;
  end

  fpalu_div_pipe #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_vld      (v2_r),
    .in_dividend (dnd2_r),
    .in_divisor  (dsr2_r),
    .in_side     (side2),
    .out_vld     (dv_vld),
    .out_quotient(dv_quo),
    .out_side    (dv_side)
  );

  always_comb begin
    quo_w = dv_side.qneg ? WORD_W'(-dv_quo[WORD_W-1:0]) : dv_quo[WORD_W-1:0];
    if (dv_side.is_div) begin
      out_res_nxt = dv_side.dz ? '0 : quo_w;
    end else begin
      out_res_nxt = dv_side.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res_r <= out_res_nxt;
      out_cmp_r <= dv_side.cmp;
      out_dz_r  <= dv_side.dz;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_value   = out_res_r;
  assign out_compare_true   = out_cmp_r;
  assign out_divide_by_zero = out_dz_r;

  a_dz_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_dz_r |-> out_res_r == '0)
    else $error("divide by zero result not zero");

  a_cmp_one : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_cmp_r |-> out_res_r == WORD_W'(1) && !out_dz_r)
    else $error("compare result inconsistent");

  a_hold_pipe : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> $stable(v1_r) && $stable(v2_r) && $stable(dv_vld))
    else $error("pipeline advanced while stalled");

  a_div_flag : assert property (@(posedge clk) disable iff (!rst_n)
    dv_vld && dv_side.dz |-> dv_side.is_div && !dv_side.cmp)
    else $error("divide by zero flag on non-divide item");

endmodule

// ----- sim/tb.sv -----
// Testbench for the Q24.8 fixed-point ALU: directed corner items and random items, checked against a predictor.
`timescale 1ns / 100ps

module tb;
  import fpalu_pkg::*;

  localparam int FRAC_BITS = 8;
  localparam int LATENCY = FRAC_BITS + 35;
  localparam int RANDOM_ITEMS = 1350;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    opcode_t                  op;
    logic signed [WORD_W-1:0] a;
    logic signed [WORD_W-1:0] b;
  } alu_op_t;

  typedef struct {
    logic signed [WORD_W-1:0] value;
    logic                     cmp;
    logic                     dz;
  } alu_result_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] in_opcode = 4'd0;
  logic signed [WORD_W-1:0] in_operand_a = '0;
  logic signed [WORD_W-1:0] in_operand_b = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [WORD_W-1:0] out_result_value;
  logic out_compare_true;
  logic out_divide_by_zero;

  alu_op_t     op_backlog[$];
  alu_result_t results_due[$];
  alu_op_t     next_op;
  alu_result_t due;
  int          n_total = 0;
  int          n_accepted = 0;
  int          err_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  logic [7:0]  stall_phase = 8'd0;

  fixed_point_q24_8_alu #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_operand_a      (in_operand_a),
    .in_operand_b      (in_operand_b),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_value  (out_result_value),
    .out_compare_true  (out_compare_true),
    .out_divide_by_zero(out_divide_by_zero)
  );

  always #5 clk = ~clk;

  function automatic alu_result_t alu_compute(input opcode_t op,
                                              input logic signed [WORD_W-1:0] a,
                                              input logic signed [WORD_W-1:0] b);
    alu_result_t r;
    longint      sa;
    longint      sb;
    longint      wide;
    sa = a;
    sb = b;
    r.value = '0;
    r.cmp = 1'b0;
    r.dz = 1'b0;
    case (op)
      OP_ADD: r.value = a + b;
      OP_SUB: r.value = a - b;
      OP_MUL: begin
        wide = (sa * sb) >>> FRAC_BITS;
        r.value = wide[WORD_W-1:0];
      end
      OP_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
        end else begin
          wide = (sa <<< FRAC_BITS) / sb;
          r.value = wide[WORD_W-1:0];
        end
      end
      OP_GT: r.cmp = (a > b);
      OP_LT: r.cmp = (a < b);
      OP_GE: r.cmp = (a >= b);
      OP_LE: r.cmp = (a <= b);
      OP_EQ: r.cmp = (a == b);
      OP_NE: r.cmp = (a != b);
      OP_MIN: r.value = (a < b) ? a : b;
      OP_MAX: r.value = (a > b) ? a : b;
      OP_INC: r.value = a + 32'sd1;
      OP_DEC: r.value = a - 32'sd1;
      OP_FROM_INT: r.value = a <<< FRAC_BITS;
      default: r.value = a >>> FRAC_BITS;
    endcase
    if (op >= OP_GT && op <= OP_NE) begin
      r.value = {{(WORD_W-1){1'b0}}, r.cmp};
    end
    return r;
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_operand();
    logic [WORD_W-1:0] v;
    case ($urandom_range(0, 7))
      3: v = $urandom_range(0, 4000) - 2000;
      4: v = ($urandom_range(0, 512) - 256) * 256 + $urandom_range(0, 255);
      5: begin
        case ($urandom_range(0, 6))
          0: v = 32'h0000_0000;
          1: v = 32'h0000_0001;
          2: v = 32'hFFFF_FFFF;
          3: v = 32'h7FFF_FFFF;
          4: v = 32'h8000_0000;
          5: v = 32'h0000_0100;
          default: v = 32'hFFFF_FF00;
        endcase
      end
      6: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 0) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic queue_op(input opcode_t op, input logic signed [WORD_W-1:0] a,
                          input logic signed [WORD_W-1:0] b);
    alu_op_t item;
    item.op = op;
    item.a = a;
    item.b = b;
    op_backlog.push_back(item);
  endtask

  task automatic check_field(input string name, input longint expected, input longint actual);
    if (expected != actual) begin
      err_count++;
      $error("%s: expected %0d, got %0d", name, expected, actual);
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        results_due.push_back(alu_compute(opcode_t'(in_opcode), in_operand_a, in_operand_b));
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (op_backlog.size() > 0) begin
          next_op = op_backlog.pop_front();
          in_opcode <= next_op.op;
          in_operand_a <= next_op.a;
          in_operand_b <= next_op.b;
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 48);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 8'd1;
      if (stall_phase == 8'd0) stall_mode <= stall_mode_t'($urandom_range(0, 3));
      case (stall_mode)
        STALL_NONE: out_stall <= 1'b0;
        STALL_RANDOM: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_PERIODIC: out_stall <= (stall_phase[2:0] < 3'd3);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        err_count++;
        $error("result_value %0d arrived with no item outstanding", out_result_value);
      end else begin
        due = results_due.pop_front();
        check_field("result_value", due.value, out_result_value);
        check_field("compare_true", due.cmp, out_compare_true);
        check_field("divide_by_zero", due.dz, out_divide_by_zero);
      end
    end
  end

  initial begin
    alu_op_t item;
    queue_op(OP_ADD, 32'sh7FFF_FFFF, 32'sd1);
    queue_op(OP_SUB, 32'sh8000_0000, 32'sd1);
    queue_op(OP_MUL, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    queue_op(OP_MUL, 32'sh8000_0000, -32'sd256);
    queue_op(OP_MUL, -32'sd3, 32'sd1);
    queue_op(OP_DIV, 32'sd5, 32'sd0);
    queue_op(OP_DIV, 32'sh8000_0000, 32'sd0);
    queue_op(OP_DIV, 32'sh8000_0000, -32'sd1);
    queue_op(OP_DIV, 32'sh7FFF_FFFF, 32'sd1);
    queue_op(OP_DIV, -32'sd3, 32'sd2);
    queue_op(OP_GT, 32'sh8000_0000, 32'sh7FFF_FFFF);
    queue_op(OP_LT, 32'sh8000_0000, 32'sh7FFF_FFFF);
    queue_op(OP_GE, 32'sd77, 32'sd77);
    queue_op(OP_LE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    queue_op(OP_EQ, 32'sh8000_0000, 32'sh8000_0000);
    queue_op(OP_NE, 32'sd0, 32'sd0);
    queue_op(OP_MIN, 32'sd7, 32'sd7);
    queue_op(OP_MAX, -32'sd1, 32'sd0);
    queue_op(OP_INC, 32'sh7FFF_FFFF, 32'sh5A5A_5A5A);
    queue_op(OP_DEC, 32'sh8000_0000, -32'sd1);
    queue_op(OP_FROM_INT, 32'sh8000_0001, 32'sd0);
    queue_op(OP_FROM_INT, 32'sh007F_FFFF, 32'sd0);
    queue_op(OP_TO_INT, -32'sd1, 32'sd0);
    queue_op(OP_TO_INT, -32'sd257, 32'sd0);
    queue_op(OP_TO_INT, 32'sh7FFF_FFFF, 32'shFFFF_FFFF);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      item.op = opcode_t'($urandom_range(0, 15));
      item.a = pick_operand();
      item.b = pick_operand();
      if (item.op == OP_DIV && $urandom_range(0, 7) == 0) item.b = '0;
      if (item.op >= OP_GT && item.op <= OP_MAX && $urandom_range(0, 4) == 0) item.b = item.a;
      op_backlog.push_back(item);
    end
    n_total = op_backlog.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted < n_total) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (err_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- files.f -----
sv/fpalu_pkg.sv
sv/fpalu_div_pipe.sv
sv/fixed_point_q24_8_alu.sv
sim/tb.sv
